/* design/bbpcm_pkg.sv */
// Shared types and constants of the buck-boost PWM compare mapper.
package bbpcm_pkg;

  localparam int F_W = 16;
  localparam int X5_W = 17;
  localparam int OUT_W = 15;
  localparam int DATA_W = 64;

  localparam int RECIP_STAGES = 7;
  localparam int RECIP_BITS = 2;
  localparam int Q_W = RECIP_STAGES * RECIP_BITS;

  localparam int DEN_SHIFT = 15;

  localparam logic [F_W-1:0] ONE_Q14 = 16'd16384;
  localparam logic [Q_W-1:0] HALF_Q14 = 14'd8192;
  localparam logic [F_W-1:0] FLOOR_LIMIT = 16'd2457;
  localparam logic [X5_W-1:0] X5_FLOOR = 17'd12288;
  localparam logic [X5_W-1:0] X5_ONE = 17'd81920;

  typedef enum logic [0:0] {
    REG_CLAMP_LO = 1'b0,
    REG_CLAMP_HI = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic             boost;
    logic [X5_W-1:0]  x5_buck;
  } side_t;

endpackage

/* design/buck_boost_pwm_compare_mapper_core.sv */
// Top level: clamps the voltage factor and maps it to four-switch bridge compare values.
// Fully pipelined: one beat is accepted every cycle unless the output stalls. Stages:
// two input/clamp stages, a seven-stage reciprocal divider resolving two quotient bits
// per stage, duty select, multiply, two divide-by-constant stages and the output
// register. A stall on the output side freezes the whole pipeline; input is refused
// only while the output register holds a beat that is not taken. The lower and upper
// clamp limits (registers 0 and 1) are sampled at the clamp stage; the user must
// write them only while idle, which the block itself does not enforce.
module buck_boost_pwm_compare_mapper_core #(
  parameter int PERIOD_TICKS = 27200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] factor
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // motor_start, motor_end, cap_start, cap_end, pad
  output logic [0:0]  m_axis_tuser    // [0] boost_mode
);

  localparam int FW = bbpcm_pkg::F_W;
  localparam int XW = bbpcm_pkg::X5_W;
  localparam int OW = bbpcm_pkg::OUT_W;
  localparam int RS = bbpcm_pkg::RECIP_STAGES;
  localparam int LAT = RS + 7;
  localparam int HALF = PERIOD_TICKS / 2;
  localparam int NINE_H = 9 * HALF;
  localparam int NH_W = $clog2(NINE_H + 1);
  localparam int PROD_W = XW + NH_W;
  localparam int T_W = PROD_W - bbpcm_pkg::DEN_SHIFT;
  localparam int PW = T_W - 4;
  localparam logic [PROD_W-1:0] NINE_H_C = PROD_W'(NINE_H);
  localparam logic [OW-1:0] FULL_FL = OW'((9 * HALF) / 10);
  localparam logic [OW-1:0] FULL_CL = OW'((9 * HALF + 9) / 10);
  localparam logic [OW-1:0] CAP_IDLE_START = OW'(HALF + (9 * HALF) / 10);
  localparam logic [OW-1:0] CAP_IDLE_END = OW'(HALF - (9 * HALF + 9) / 10);

  logic [FW-1:0] clamp_lo_q;
  logic [FW-1:0] clamp_hi_q;
  logic [LAT-1:0] vld_q;
  logic en;

  logic [FW-1:0] f_in_q;
  logic [FW-1:0] fc_d, fc_q;
  bbpcm_pkg::side_t side_d, side1_q;
  bbpcm_pkg::side_t side_q [RS];
  logic [bbpcm_pkg::Q_W-1:0] quo;
  logic [bbpcm_pkg::Q_W-1:0] qc;
  logic          boost9_q, boost10_q, boost11_q, boost12_q;
  logic [XW-1:0] xm5_q, xc5_q;
  logic [PROD_W-1:0] prodm_q, prodc_q;
  logic [PW-1:0] mf, mc, cf, cc;
  logic [OW-1:0] motor_start_q, motor_end_q, cap_start_q, cap_end_q;
  logic          boost_out_q;

  assign en = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clamp_lo_q <= 16'd2458;
      clamp_hi_q <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (bbpcm_pkg::cfg_reg_e'(cfg_idx_i))
        bbpcm_pkg::REG_CLAMP_LO: clamp_lo_q <= cfg_wdata_i;
        bbpcm_pkg::REG_CLAMP_HI: clamp_hi_q <= cfg_wdata_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  always_comb begin
    if (f_in_q < clamp_lo_q) begin
      fc_d = clamp_lo_q;
    end else if (f_in_q > clamp_hi_q) begin
      fc_d = clamp_hi_q;
    end else begin
      fc_d = f_in_q;
    end
    side_d.boost = fc_d > bbpcm_pkg::ONE_Q14;
    if (fc_d <= bbpcm_pkg::FLOOR_LIMIT) begin
      side_d.x5_buck = bbpcm_pkg::X5_FLOOR;
    end else begin
      side_d.x5_buck = XW'({fc_d, 2'b00}) + XW'(fc_d);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_in_q  <= s_axis_tdata;
      fc_q    <= fc_d;
      side1_q <= side_d;
      side_q[0] <= side1_q;
      for (int k = 1; k < RS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  bbpcm_recip u_recip (
    .clk_i (clk_i),
    .en_i  (en),
    .f_i   (fc_q),
    .q_o   (quo)
  );

  assign qc = (quo < bbpcm_pkg::HALF_Q14) ? bbpcm_pkg::HALF_Q14 : quo;

  always_ff @(posedge clk_i) begin
    if (en) begin
      boost9_q <= side_q[RS-1].boost;
      if (side_q[RS-1].boost) begin
        xm5_q <= bbpcm_pkg::X5_ONE;
        xc5_q <= XW'({qc, 2'b00}) + XW'(qc);
      end else begin
        xm5_q <= side_q[RS-1].x5_buck;
        xc5_q <= bbpcm_pkg::X5_ONE;
      end
      boost10_q <= boost9_q;
      prodm_q   <= PROD_W'(xm5_q) * NINE_H_C;
      prodc_q   <= PROD_W'(xc5_q) * NINE_H_C;
      boost11_q <= boost10_q;
      boost12_q <= boost11_q;
    end
  end

  bbpcm_div25 #(.T_W(T_W)) u_div_motor (
    .clk_i     (clk_i),
    .en_i      (en),
    .t_i       (prodm_q[PROD_W-1:bbpcm_pkg::DEN_SHIFT]),
    .frac_nz_i (|prodm_q[bbpcm_pkg::DEN_SHIFT-1:0]),
    .floor_o   (mf),
    .ceil_o    (mc)
  );

  bbpcm_div25 #(.T_W(T_W)) u_div_cap (
    .clk_i     (clk_i),
    .en_i      (en),
    .t_i       (prodc_q[PROD_W-1:bbpcm_pkg::DEN_SHIFT]),
    .frac_nz_i (|prodc_q[bbpcm_pkg::DEN_SHIFT-1:0]),
    .floor_o   (cf),
    .ceil_o    (cc)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      motor_start_q <= OW'(mf);
      motor_end_q   <= OW'(32'(PERIOD_TICKS) - 32'(mc));
      cap_start_q   <= OW'(32'(HALF) + 32'(cf));
      cap_end_q     <= OW'(32'(HALF) - 32'(cc));
      boost_out_q   <= boost12_q;
    end
  end

  assign m_axis_tdata = {(bbpcm_pkg::DATA_W - 4 * OW)'(0),
                         cap_end_q, cap_start_q, motor_end_q, motor_start_q};
  assign m_axis_tuser = boost_out_q;

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output register");

  a_buck_cap_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |->
      cap_start_q == CAP_IDLE_START && cap_end_q == CAP_IDLE_END)
    else $error("buck beat with modulated cap leg");

  a_boost_motor_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      motor_start_q == FULL_FL && motor_end_q == OW'(32'(PERIOD_TICKS) - 32'(FULL_CL)))
    else $error("boost beat with modulated motor leg");

endmodule

/* design/bbpcm_recip.sv */
// Pipelined restoring divider computing floor(2^28 / f), two quotient bits per stage.
module bbpcm_recip (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [bbpcm_pkg::F_W-1:0] f_i,
  output logic [bbpcm_pkg::Q_W-1:0] q_o
);

  localparam int RS = bbpcm_pkg::RECIP_STAGES;
  localparam int FW = bbpcm_pkg::F_W;
  localparam int QW = bbpcm_pkg::Q_W;

  logic [FW-1:0] rem_q [RS];
  logic [FW-1:0] f_q   [RS];
  logic [QW-1:0] quo_q [RS];

  for (genvar s = 0; s < RS; s++) begin : g_stage
    logic [FW-1:0] rem_in;
    logic [FW-1:0] f_in;
    logic [QW-1:0] quo_in;
    logic [FW-1:0] rem_d;
    logic [QW-1:0] quo_d;
    logic [FW:0]   shl;

    if (s == 0) begin : g_first
      assign rem_in = bbpcm_pkg::ONE_Q14;
      assign f_in   = f_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign f_in   = f_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      shl   = '0;
      for (int b = 0; b < bbpcm_pkg::RECIP_BITS; b++) begin
        shl = {rem_d, 1'b0};
        if (shl >= {1'b0, f_in}) begin
          rem_d = FW'(shl - {1'b0, f_in});
          quo_d = {quo_d[QW-2:0], 1'b1};
        end else begin
          rem_d = shl[FW-1:0];
          quo_d = {quo_d[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        f_q[s]   <= f_in;
        quo_q[s] <= quo_d;
      end
    end
  end

  assign q_o = quo_q[RS-1];

endmodule

/* design/bbpcm_div25.sv */
// Two-stage floor and ceil of (t * 2^15 + frac) / (25 * 2^15) by reciprocal multiply.
module bbpcm_div25 #(
  parameter int T_W = 19
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [T_W-1:0] t_i,
  input  logic           frac_nz_i,
  output logic [T_W-5:0] floor_o,
  output logic [T_W-5:0] ceil_o
);

  localparam int SHIFT = T_W + 5;
  localparam int R_W = SHIFT - 4;
  localparam int M_W = T_W + R_W;
  localparam int PW = T_W - 4;
  localparam logic [R_W-1:0] RECIP = R_W'((longint'(1) << SHIFT) / 25);
  localparam logic [T_W-1:0] DIV_C = T_W'(25);

  logic [M_W-1:0] prod;
  logic [T_W-1:0] t_q;
  logic [PW-1:0]  q0_q;
  logic           nz_q;
  logic [T_W-1:0] rem;
  logic [T_W-1:0] rem_fix;
  logic [PW-1:0]  fl_d;
  logic           exact;
  logic [PW-1:0]  floor_q;
  logic [PW-1:0]  ceil_q;

  assign prod = M_W'(t_i) * M_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q  <= t_i;
      q0_q <= prod[M_W-1:SHIFT];
      nz_q <= frac_nz_i;
    end
  end

  // estimate is low by at most one
  always_comb begin
    rem = t_q - T_W'(T_W'(q0_q) * DIV_C);
    if (rem >= DIV_C) begin
      fl_d    = q0_q + PW'(1);
      rem_fix = rem - DIV_C;
    end else begin
      fl_d    = q0_q;
      rem_fix = rem;
    end
    exact = (rem_fix == '0) && !nz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      floor_q <= fl_d;
      ceil_q  <= fl_d + PW'(!exact);
    end
  end

  assign floor_o = floor_q;
  assign ceil_o  = ceil_q;

endmodule
